// ===== src/twtl_pkg.sv =====
// ----------------------------------------------------------------------------
// twtl_pkg
// Types, constants and decode helpers for the two-way traffic light with
// countdown display.
// ----------------------------------------------------------------------------
`default_nettype none

package twtl_pkg;

    localparam int ROUNDS_PER_SECOND_DEF = 25;

    localparam int SECONDS_W = 7;
    localparam int YELLOW_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [SECONDS_W-1:0] SOUTH_SECONDS_RST = 7'd15;
    localparam logic [SECONDS_W-1:0] WEST_SECONDS_RST  = 7'd23;
    localparam logic [YELLOW_W-1:0]  YELLOW_SECONDS_RST = 4'd3;

    localparam logic [SECONDS_W-1:0] DISPLAY_MAX = 7'd99;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUTH_SECONDS = 2'd0,
        CFG_WEST_SECONDS  = 2'd1,
        CFG_YELLOW_SECONDS = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_SOUTH = 2'b01,
        MODE_WEST  = 2'b10
    } t_mode;

    typedef enum logic [2:0] {
        OVR_IDLE  = 3'b001,
        OVR_COUNT = 3'b010,
        OVR_HOLD  = 3'b100
    } t_ovr_phase;

    typedef struct packed {
        logic override_request;
        logic override_to_west;
    } t_in_item;

    typedef struct packed {
        logic [3:0] digit_enables_n;
        logic [7:0] segments;
        logic       south_green;
        logic       south_yellow;
        logic       south_red;
        logic       west_green;
        logic       west_yellow;
        logic       west_red;
    } t_out_item;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hbf;
            4'd1:    code = 8'h86;
            4'd2:    code = 8'hdb;
            4'd3:    code = 8'hcf;
            4'd4:    code = 8'he6;
            4'd5:    code = 8'hed;
            4'd6:    code = 8'hfd;
            4'd7:    code = 8'h87;
            4'd8:    code = 8'hff;
            4'd9:    code = 8'hef;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // valid for values up to 99
    function automatic logic [3:0] dec_tens(input logic [SECONDS_W-1:0] value);
        logic [14:0] prod;
        prod = 15'(value) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] dec_units(input logic [SECONDS_W-1:0] value);
        logic [3:0]           tens;
        logic [SECONDS_W-1:0] rest;
        tens = dec_tens(value);
        rest = value - SECONDS_W'({tens, 3'b000} + {2'b00, tens, 1'b0});
        return rest[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/two_way_traffic_light_with_countdown.sv =====
// ----------------------------------------------------------------------------
// two_way_traffic_light_with_countdown
// Two-phase traffic light with multiplexed two-digit countdowns per direction
// and a manual override with a one-digit yellow countdown.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per
//   10 ms display slot, carrying the override switch levels.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transfer per
//   input transfer with the digit strobes, segment pattern and six lamps.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): south phase, west
//   phase and yellow seconds; index 3 is ignored. Write only while idle.
//   Path: a transfer is captured in the input register, evaluated
//   combinationally and lands in the output register once the output is
//   not stalled.
//   Throughput: one transfer per cycle while the output is not stalled, set
//   by the single evaluation stage between the input and output registers.
//   Reset: south phase at 15 s, yellow 3 s, override idle, both channels empty.
//   Stall: a stalled result holds in the output register; an empty input
//   register takes one more transfer, then o_in_stall rises until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_traffic_light_with_countdown #(
    parameter int ROUNDS_PER_SECOND = twtl_pkg::ROUNDS_PER_SECOND_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  twtl_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output twtl_pkg::t_out_item                o_out_data,
    input  wire                                i_cfg_we,
    input  wire [twtl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [twtl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SlotW = $clog2(ROUNDS_PER_SECOND + 1);
    localparam int SecW  = twtl_pkg::SECONDS_W;
    localparam int YelW  = twtl_pkg::YELLOW_W;
    localparam logic [SlotW-1:0] RoundsMax = SlotW'(ROUNDS_PER_SECOND);

    logic [SecW-1:0]          r_south_secs;
    logic [SecW-1:0]          r_west_secs;
    logic [YelW-1:0]          r_yellow_secs;

    logic                     r_in_valid;
    twtl_pkg::t_in_item       r_in_data;
    logic                     r_out_valid;
    twtl_pkg::t_out_item      r_out_data;

    twtl_pkg::t_mode          r_mode, n_mode;
    logic [SecW-1:0]          r_sec_left, n_sec_left;
    logic [SlotW-1:0]         r_slot, n_slot;
    logic [1:0]               r_scan, n_scan;
    twtl_pkg::t_ovr_phase     r_ovr_phase, n_ovr_phase;
    logic [YelW-1:0]          r_ovr_sec, n_ovr_sec;
    logic [SlotW-1:0]         r_ovr_slot, n_ovr_slot;
    logic [1:0]               r_ovr_scan, n_ovr_scan;
    logic                     r_ovr_dir, n_ovr_dir;
    logic                     r_last_req, n_last_req;
    twtl_pkg::t_out_item      n_out_data;

    logic                     advance;
    logic                     req;
    logic                     west;
    logic                     start;
    twtl_pkg::t_ovr_phase     phase_start;
    twtl_pkg::t_ovr_phase     phase_eff;
    logic                     dir_eff;
    logic [YelW-1:0]          osec_eff;
    logic [SlotW-1:0]         oslot_eff;
    logic [1:0]               oscan_eff;
    logic [SlotW-1:0]         oslot_inc;
    logic [YelW-1:0]          osec_dec;
    logic [3:0]               osec_units;

    logic                     is_yellow;
    logic [SecW-1:0]          other_val;
    logic [SecW-1:0]          south_val;
    logic [SecW-1:0]          west_val;
    logic [SecW-1:0]          shown_val;
    logic [SecW-1:0]          sat_val;
    logic [3:0]               digit;
    logic [SlotW-1:0]         slot_inc;

    // Handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Override entry and hold exit
    assign req   = r_in_data.override_request;
    assign west  = r_in_data.override_to_west;
    assign start = (r_ovr_phase == twtl_pkg::OVR_IDLE) && req && !r_last_req;
    assign phase_start = (r_yellow_secs != '0) ? twtl_pkg::OVR_COUNT : twtl_pkg::OVR_HOLD;
    assign dir_eff   = start ? west : r_ovr_dir;
    assign osec_eff  = start ? r_yellow_secs : r_ovr_sec;
    assign oslot_eff = start ? '0 : r_ovr_slot;
    assign oscan_eff = start ? 2'd0 : r_ovr_scan;

    always_comb begin
        phase_eff = start ? phase_start : r_ovr_phase;
        if (phase_eff == twtl_pkg::OVR_HOLD && !(req && (west == dir_eff))) begin
            phase_eff = twtl_pkg::OVR_IDLE;
        end
    end

    assign oslot_inc  = oslot_eff + SlotW'(1);
    assign osec_dec   = osec_eff - YelW'(1);
    assign osec_units = (osec_eff >= YelW'(10)) ? osec_eff - YelW'(10) : osec_eff;

    // Normal display values
    assign is_yellow = !(r_sec_left > SecW'(r_yellow_secs));
    assign other_val = is_yellow ? r_sec_left : r_sec_left - SecW'(r_yellow_secs);
    assign south_val = (r_mode == twtl_pkg::MODE_WEST) ? other_val : r_sec_left;
    assign west_val  = (r_mode == twtl_pkg::MODE_WEST) ? r_sec_left : other_val;
    assign shown_val = r_scan[1] ? west_val : south_val;
    assign sat_val   = (shown_val > twtl_pkg::DISPLAY_MAX) ? twtl_pkg::DISPLAY_MAX : shown_val;
    assign digit     = r_scan[0] ? twtl_pkg::dec_units(sat_val) : twtl_pkg::dec_tens(sat_val);
    assign slot_inc  = r_slot + SlotW'(1);

    always_comb begin
        n_mode      = r_mode;
        n_sec_left  = r_sec_left;
        n_slot      = r_slot;
        n_scan      = r_scan;
        n_ovr_phase = phase_eff;
        n_ovr_sec   = osec_eff;
        n_ovr_slot  = oslot_eff;
        n_ovr_scan  = oscan_eff;
        n_ovr_dir   = dir_eff;
        n_last_req  = req;
        n_out_data  = '0;

        case (phase_eff)
            twtl_pkg::OVR_COUNT: begin
                n_out_data.digit_enables_n = dir_eff ? 4'h7 : 4'hD;
                n_out_data.segments        = twtl_pkg::seg_code(osec_units);
                n_out_data.south_yellow    = dir_eff;
                n_out_data.south_red       = !dir_eff;
                n_out_data.west_yellow     = !dir_eff;
                n_out_data.west_red        = dir_eff;
                n_ovr_scan = oscan_eff + 2'd1;
                if (oscan_eff == 2'd3) begin
                    n_ovr_slot = oslot_inc;
                    if (oslot_inc >= RoundsMax) begin
                        n_ovr_slot = '0;
                        n_ovr_sec  = osec_dec;
                        if (osec_dec == '0) begin
                            n_ovr_phase = twtl_pkg::OVR_HOLD;
                        end
                    end
                end
            end
            twtl_pkg::OVR_HOLD: begin
                n_out_data.digit_enables_n = 4'hF;
                n_out_data.segments        = 8'h00;
                n_out_data.south_green     = !dir_eff;
                n_out_data.south_red       = dir_eff;
                n_out_data.west_green      = dir_eff;
                n_out_data.west_red        = !dir_eff;
            end
            default: begin
                n_out_data.digit_enables_n = 4'(~(4'b0001 << r_scan));
                n_out_data.segments        = twtl_pkg::seg_code(digit);
                if (r_mode == twtl_pkg::MODE_WEST) begin
                    n_out_data.south_red   = 1'b1;
                    n_out_data.west_green  = !is_yellow;
                    n_out_data.west_yellow = is_yellow;
                end else begin
                    n_out_data.south_green  = !is_yellow;
                    n_out_data.south_yellow = is_yellow;
                    n_out_data.west_red     = 1'b1;
                end
                n_scan = r_scan + 2'd1;
                if (r_scan == 2'd3) begin
                    n_slot = slot_inc;
                    if (slot_inc >= RoundsMax) begin
                        n_slot = '0;
                        if (r_sec_left > SecW'(1)) begin
                            n_sec_left = r_sec_left - SecW'(1);
                        end else if (r_mode == twtl_pkg::MODE_WEST) begin
                            n_mode     = twtl_pkg::MODE_SOUTH;
                            n_sec_left = r_south_secs;
                        end else begin
                            n_mode     = twtl_pkg::MODE_WEST;
                            n_sec_left = r_west_secs;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_south_secs  <= twtl_pkg::SOUTH_SECONDS_RST;
            r_west_secs   <= twtl_pkg::WEST_SECONDS_RST;
            r_yellow_secs <= twtl_pkg::YELLOW_SECONDS_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= twtl_pkg::MODE_SOUTH;
            r_sec_left    <= twtl_pkg::SOUTH_SECONDS_RST;
            r_slot        <= '0;
            r_scan        <= 2'd0;
            r_ovr_phase   <= twtl_pkg::OVR_IDLE;
            r_ovr_sec     <= '0;
            r_ovr_slot    <= '0;
            r_ovr_scan    <= 2'd0;
            r_ovr_dir     <= 1'b0;
            r_last_req    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    twtl_pkg::CFG_SOUTH_SECONDS:  r_south_secs  <= i_cfg_data;
                    twtl_pkg::CFG_WEST_SECONDS:   r_west_secs   <= i_cfg_data;
                    twtl_pkg::CFG_YELLOW_SECONDS: r_yellow_secs <= i_cfg_data[YelW-1:0];
                    default: ;
                endcase
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_mode      <= n_mode;
                r_sec_left  <= n_sec_left;
                r_slot      <= n_slot;
                r_scan      <= n_scan;
                r_ovr_phase <= n_ovr_phase;
                r_ovr_sec   <= n_ovr_sec;
                r_ovr_slot  <= n_ovr_slot;
                r_ovr_scan  <= n_ovr_scan;
                r_ovr_dir   <= n_ovr_dir;
                r_last_req  <= n_last_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    a_one_lamp_each : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot({o_out_data.south_green, o_out_data.south_yellow,
                                  o_out_data.south_red})
                         && $onehot({o_out_data.west_green, o_out_data.west_yellow,
                                     o_out_data.west_red})))
        else $error("lamp set not one-hot per direction");

    a_blank_segments : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.digit_enables_n == 4'hF) |-> o_out_data.segments == 8'h00)
        else $error("segments lit with all digits off");

    a_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovr_phase == twtl_pkg::OVR_COUNT) |-> (r_ovr_sec != '0))
        else $error("override countdown at zero");

    a_slot_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot < RoundsMax) && (r_ovr_slot < RoundsMax))
        else $error("round counter out of range");

endmodule

`default_nettype wire

// ===== verif/twtl_checker.sv =====
// ----------------------------------------------------------------------------
// twtl_checker
// Watches the slot and display channels of the traffic light and its register
// port. It keeps its own copy of the phase timing, scan position and manual
// override state. It predicts one display transfer per accepted slot transfer
// and compares each display transfer field by field with the oldest
// prediction. It reports the mismatch count, the open predictions and a few
// coverage counts to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module twtl_checker #(
    parameter int ROUNDS_PER_SECOND = twtl_pkg::ROUNDS_PER_SECOND_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  twtl_pkg::t_in_item             i_in_data,
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  twtl_pkg::t_out_item            i_out_data,
    input  wire                            i_cfg_we,
    input  wire [twtl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [twtl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_phase_changes,
    output int                             o_override_starts
);
    timeunit 1ns;
    timeprecision 1ps;
    import twtl_pkg::*;

    logic [SECONDS_W-1:0] south_len;
    logic [SECONDS_W-1:0] west_len;
    logic [YELLOW_W-1:0]  yellow_len;

    t_mode                phase;
    logic [SECONDS_W-1:0] secs;
    logic [6:0]           rounds;
    logic [1:0]           scan;
    t_ovr_phase           ovr_phase;
    logic [YELLOW_W-1:0]  ovr_secs;
    logic [6:0]           ovr_rounds;
    logic [1:0]           ovr_scan;
    logic                 ovr_west;
    logic                 last_req;

    logic [7:0]           seg_lut [0:9];
    t_out_item            expected_displays [$];

    initial begin
        seg_lut[0] = 8'hbf;
        seg_lut[1] = 8'h86;
        seg_lut[2] = 8'hdb;
        seg_lut[3] = 8'hcf;
        seg_lut[4] = 8'he6;
        seg_lut[5] = 8'hed;
        seg_lut[6] = 8'hfd;
        seg_lut[7] = 8'h87;
        seg_lut[8] = 8'hff;
        seg_lut[9] = 8'hef;
    end

    task automatic clear_state;
        south_len  = SOUTH_SECONDS_RST;
        west_len   = WEST_SECONDS_RST;
        yellow_len = YELLOW_SECONDS_RST;
        phase      = MODE_SOUTH;
        secs       = SOUTH_SECONDS_RST;
        rounds     = '0;
        scan       = '0;
        ovr_phase  = OVR_IDLE;
        ovr_secs   = '0;
        ovr_rounds = '0;
        ovr_scan   = '0;
        ovr_west   = 1'b0;
        last_req   = 1'b0;
    endtask

    task automatic advance_slot(input t_in_item slot, output t_out_item disp);
        logic                 req;
        logic                 west;
        logic                 rising;
        logic                 yel;
        logic [SECONDS_W-1:0] n;
        logic [SECONDS_W-1:0] s_val;
        logic [SECONDS_W-1:0] w_val;
        logic [SECONDS_W-1:0] shown;
        logic [3:0]           digit;

        req      = slot.override_request;
        west     = slot.override_to_west;
        rising   = req && !last_req;
        last_req = req;
        disp     = '0;

        if (ovr_phase == OVR_IDLE && rising) begin
            ovr_west   = west;
            ovr_secs   = yellow_len;
            ovr_rounds = '0;
            ovr_scan   = '0;
            ovr_phase  = (yellow_len != '0) ? OVR_COUNT : OVR_HOLD;
            o_override_starts++;
        end
        if (ovr_phase == OVR_HOLD && !(req && west == ovr_west)) begin
            ovr_phase = OVR_IDLE;
        end

        case (ovr_phase)
            OVR_COUNT: begin
                if (ovr_west) begin
                    disp.digit_enables_n = 4'h7;
                    disp.south_yellow    = 1'b1;
                    disp.west_red        = 1'b1;
                end else begin
                    disp.digit_enables_n = 4'hd;
                    disp.south_red       = 1'b1;
                    disp.west_yellow     = 1'b1;
                end
                disp.segments = seg_lut[ovr_secs % 10];
                ovr_scan = ovr_scan + 2'd1;
                if (ovr_scan == 2'd0) begin
                    ovr_rounds = ovr_rounds + 7'd1;
                    if (ovr_rounds >= ROUNDS_PER_SECOND) begin
                        ovr_rounds = '0;
                        ovr_secs   = ovr_secs - 4'd1;
                        if (ovr_secs == '0) begin
                            ovr_phase = OVR_HOLD;
                        end
                    end
                end
            end
            OVR_HOLD: begin
                disp.digit_enables_n = 4'hf;
                disp.segments        = 8'h00;
                disp.south_green     = !ovr_west;
                disp.south_red       = ovr_west;
                disp.west_green      = ovr_west;
                disp.west_red        = !ovr_west;
            end
            default: begin
                n   = secs;
                yel = !(n > yellow_len);
                if (phase == MODE_WEST) begin
                    w_val            = n;
                    s_val            = yel ? n : n - yellow_len;
                    disp.south_red   = 1'b1;
                    disp.west_green  = !yel;
                    disp.west_yellow = yel;
                end else begin
                    s_val             = n;
                    w_val             = yel ? n : n - yellow_len;
                    disp.south_green  = !yel;
                    disp.south_yellow = yel;
                    disp.west_red     = 1'b1;
                end
                shown = (scan < 2'd2) ? s_val : w_val;
                if (shown > DISPLAY_MAX) begin
                    shown = DISPLAY_MAX;
                end
                digit = scan[0] ? 4'(shown % 10) : 4'(shown / 10);
                disp.digit_enables_n = ~(4'b0001 << scan);
                disp.segments        = seg_lut[digit];

                scan = scan + 2'd1;
                if (scan == 2'd0) begin
                    rounds = rounds + 7'd1;
                    if (rounds >= ROUNDS_PER_SECOND) begin
                        rounds = '0;
                        if (n > 7'd1) begin
                            secs = n - 7'd1;
                        end else if (phase == MODE_WEST) begin
                            phase = MODE_SOUTH;
                            secs  = south_len;
                            o_phase_changes++;
                        end else begin
                            phase = MODE_WEST;
                            secs  = west_len;
                            o_phase_changes++;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            clear_state();
            expected_displays.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SOUTH_SECONDS:  south_len  = i_cfg_data[SECONDS_W-1:0];
                    CFG_WEST_SECONDS:   west_len   = i_cfg_data[SECONDS_W-1:0];
                    CFG_YELLOW_SECONDS: yellow_len = i_cfg_data[YELLOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_displays.size() == 0) begin
                    $error("display transfer with nothing expected: %h", got);
                    o_errors++;
                end else begin
                    want = expected_displays.pop_front();
                    check_field("digit_enables_n", want.digit_enables_n, got.digit_enables_n);
                    check_field("segments", want.segments, got.segments);
                    check_field("south_green", want.south_green, got.south_green);
                    check_field("south_yellow", want.south_yellow, got.south_yellow);
                    check_field("south_red", want.south_red, got.south_red);
                    check_field("west_green", want.west_green, got.west_green);
                    check_field("west_yellow", want.west_yellow, got.west_yellow);
                    check_field("west_red", want.west_red, got.west_red);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_slot(i_in_data, want);
                expected_displays.push_back(want);
            end
        end
        o_pending = expected_displays.size();
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the traffic light testbench. It drives 10 ms slot transfers and
// register writes into the block and plays the display side with random and
// long stalls. A checker beside the block predicts and compares every
// display transfer. The run covers zero yellow time, a yellow time above nine,
// zero and saturating phase lengths, override in both directions with its
// exits, and back pressure. It ends with a pass or fail verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import twtl_pkg::*;

    localparam int                   ROUNDS           = ROUNDS_PER_SECOND_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX  = 2'd3;
    localparam int                   LONG_HOLD_CYCLES = 80;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   errors;
    int   pending;
    int   checked;
    int   phase_changes;
    int   override_starts;
    int   slots_sent  = 0;
    int   tx_idle_pct = 34;
    int   rx_idle_pct = 59;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_ack    = 1'b0;
    int   guard;

    two_way_traffic_light_with_countdown #(
        .ROUNDS_PER_SECOND(ROUNDS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    twtl_checker #(
        .ROUNDS_PER_SECOND(ROUNDS)
    ) display_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_phase_changes  (phase_changes),
        .o_override_starts(override_starts)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // display side: random stalls, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_slot(input logic req, input logic west);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid                 <= 1'b1;
        in_data.override_request <= req;
        in_data.override_to_west <= west;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        slots_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic load_timing(input logic [CFG_DATA_W-1:0] south_s,
                               input logic [CFG_DATA_W-1:0] west_s,
                               input logic [CFG_DATA_W-1:0] yellow_s);
        write_reg(CFG_SOUTH_SECONDS, south_s);
        write_reg(CFG_WEST_SECONDS, west_s);
        write_reg(CFG_YELLOW_SECONDS, yellow_s);
        cfg_we <= 1'b0;
    endtask

    // runs of steady switch levels and short runs of random levels; a zero override length keeps the switch off
    task automatic drive_traffic(input int count, input int max_normal, input int max_override);
        int   sent;
        int   len;
        int   pick;
        int   k;
        logic west;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = $urandom_range(max_normal, 1);
                for (k = 0; k < len && sent < count; k++) begin
                    send_slot(1'b0, 1'($urandom_range(1)));
                    sent++;
                end
            end else if (pick < 85 && max_override != 0) begin
                west = 1'($urandom_range(1));
                len  = $urandom_range(max_override, 1);
                for (k = 0; k < len && sent < count; k++) begin
                    send_slot(1'b1, west);
                    sent++;
                end
            end else begin
                len = $urandom_range(6, 1);
                for (k = 0; k < len && sent < count; k++) begin
                    send_slot(max_override != 0 ? 1'($urandom_range(1)) : 1'b0,
                              1'($urandom_range(1)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b1);
        send_slot(1'b0, 1'b0);
        wait_drained();

        // zero yellow: override jumps straight to hold
        write_reg(CFG_SPARE_INDEX, 7'h7f);
        load_timing(7'd1, 7'd0, 7'd0);
        send_slot(1'b1, 1'b1);
        send_slot(1'b1, 1'b1);
        send_slot(1'b1, 1'b0);
        send_slot(1'b1, 1'b1);
        send_slot(1'b0, 1'b0);
        send_slot(1'b1, 1'b0);
        send_slot(1'b1, 1'b0);
        send_slot(1'b0, 1'b1);
        drive_traffic(200, 120, 40);
        wait_drained();

        // largest lengths: the counts saturate once a phase reloads
        load_timing(7'd127, 7'd127, 7'd15);
        drive_traffic(150, 60, 0);
        wait_drained();

        // yellow above nine, longer than both phases
        tx_idle_pct = 59;
        rx_idle_pct = 34;
        load_timing(7'd4, 7'd5, 7'd10);
        send_slot(1'b0, 1'b0);
        send_slot(1'b1, 1'b1);
        drive_traffic(120, 40, 250);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_timing(7'd2, 7'd3, 7'd1);
        send_slot(1'b0, 1'b0);
        send_slot(1'b1, 1'b0);
        drive_traffic(60, 40, 250);
        hold_req <= ~hold_req;
        drive_traffic(40, 40, 250);
        wait_drained();
        drive_traffic(60, 40, 250);

        in_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pending != 0; guard++) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        if (pending != 0) begin
            $error("%0d display transfers never arrived", pending);
        end
        $display("summary: %0d slots sent, %0d displays checked, %0d mismatches",
                 slots_sent, checked, errors);
        $display("summary: %0d phase changes, %0d override starts",
                 phase_changes, override_starts);
        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== two_way_traffic_light_with_countdown.f =====
src/twtl_pkg.sv
src/two_way_traffic_light_with_countdown.sv
verif/twtl_checker.sv
verif/tb.sv
